// ===== sv/mrsa_pkg.sv =====
// Shared types and constants for the mark/release stack allocator.
// Used by mrsa_fit and mark_release_stack_allocator; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mrsa_pkg;

    // Address and field widths
    localparam int ADDR_W     = 28;
    localparam int NEED_W     = ADDR_W + 1;
    localparam int AREA_COUNT = 2;

    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [NEED_W-1:0] need_t;

    // Operation codes
    localparam logic [1:0] FUNC_ALLOC  = 2'd0;
    localparam logic [1:0] FUNC_FREE   = 2'd1;
    localparam logic [1:0] FUNC_REWIND = 2'd2;
    localparam logic [1:0] FUNC_LOCK   = 2'd3;

    // Result status codes
    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_NO_SPACE = 2'd1;
    localparam logic [1:0] STAT_BAD_FREE = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] REG_AREA0_START = 2'd0;
    localparam logic [1:0] REG_AREA1_START = 2'd1;
    localparam logic [1:0] REG_AREA0_END   = 2'd2;
    localparam logic [1:0] REG_AREA1_END   = 2'd3;

    // Configuration reset values
    localparam addr_t AREA0_START_RST = 28'h0200000;
    localparam addr_t AREA1_START_RST = 28'h6004000;
    localparam addr_t AREA0_END_RST   = 28'h0300000;
    localparam addr_t AREA1_END_RST   = 28'h6100000;

    // Room report of one area
    typedef struct packed {
        logic  fits;
        addr_t room;
    } fit_t;

endpackage : mrsa_pkg

`default_nettype wire

// ===== sv/mrsa_fit.sv =====
// Free-room calculation and fit test for one allocation area.
// Depends on mrsa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mrsa_fit (
    input  mrsa_pkg::addr_t top,
    input  mrsa_pkg::addr_t end_addr,
    input  mrsa_pkg::need_t need,
    output mrsa_pkg::fit_t  result
);
    import mrsa_pkg::*;

    addr_t room;

    // Saturate room to zero when the top is at or past the end
    assign room = (end_addr > top) ? (end_addr - top) : '0;

    // Serve only when the room strictly exceeds the rounded size
    assign result.room = room;
    assign result.fits = ({1'b0, room} > need);

endmodule : mrsa_fit

`default_nettype wire

// ===== sv/mark_release_stack_allocator.sv =====
// Mark/release stack allocator for two areas: mark memory, control sequencer.
// Depends on mrsa_pkg and mrsa_fit.
`timescale 1ns / 1ps
`default_nettype none

// Two-area bump allocator with a ring of MARK_DEPTH marks per area held in one
// synchronous mark memory (one write port, two registered read ports). Alloc,
// free and lock pass through an execute step, against the cached tops and the
// mark read issued at acceptance, and a done step that forms the free-byte
// report and accepts the next item once the result register is free. A rewind
// adds reload steps S_RW0 and S_RW1 before done, as the base mark of each area
// goes through the single write port in turn; the first item after reset runs
// that load first. No clearing pass runs after reset. Configuration writes take
// effect at once for ends, and for starts at the next rewind while unlocked.
module mark_release_stack_allocator #(
    parameter int MARK_DEPTH = 8
) (
    input  wire         aclk,
    input  wire         aresetn,
    // Input stream
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [55:0] s_tdata,   // [27:0] size, [55:28] addr
    input  wire  [2:0]  s_tuser,   // [1:0] func, [2] area
    // Result stream
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [55:0] m_tdata,   // [27:0] block_addr, [55:28] free_bytes
    output logic [2:0]  m_tuser,   // [1:0] status, [2] served_area
    // Configuration write port
    input  wire         cfg_we,
    input  wire  [1:0]  cfg_index,
    input  wire  [27:0] cfg_wdata
);
    import mrsa_pkg::*;

    localparam int IDX_W     = (MARK_DEPTH > 1) ? $clog2(MARK_DEPTH) : 1;
    localparam int MEM_DEPTH = AREA_COUNT * MARK_DEPTH;
    localparam int MEM_AW    = $clog2(MEM_DEPTH);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_RW0  = 3'd2;
    localparam logic [2:0] S_RW1  = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    typedef logic [IDX_W-1:0] idx_t;

    function automatic idx_t ring_next(input idx_t i);
        ring_next = (i == IDX_W'(MARK_DEPTH - 1)) ? '0 : i + 1'b1;
    endfunction

    function automatic idx_t ring_prev(input idx_t i);
        ring_prev = (i == '0) ? IDX_W'(MARK_DEPTH - 1) : i - 1'b1;
    endfunction

    function automatic logic [MEM_AW-1:0] mem_addr(input logic a, input idx_t i);
        mem_addr = (a ? MEM_AW'(MARK_DEPTH) : MEM_AW'(0)) + MEM_AW'(i);
    endfunction

    // Configuration
    addr_t cfg_start_reg [AREA_COUNT];
    addr_t cfg_end_reg   [AREA_COUNT];

    // Control and allocator state
    logic [2:0] state_reg, state_next;
    addr_t      top_reg  [AREA_COUNT];
    addr_t      top_next [AREA_COUNT];
    idx_t       idx_reg  [AREA_COUNT];
    idx_t       idx_next [AREA_COUNT];
    addr_t      lock_reg [AREA_COUNT];
    addr_t      lock_next[AREA_COUNT];
    logic       locked_reg, locked_next;
    logic       loaded_reg, loaded_next;

    // Held item and partial result
    logic [1:0] func_reg, func_next;
    logic       area_reg, area_next;
    addr_t      size_reg, size_next;
    addr_t      addr_reg, addr_next;
    addr_t      blk_reg, blk_next;
    logic [1:0] status_reg, status_next;
    logic       served_reg, served_next;

    // Output register
    logic        m_tvalid_reg, m_tvalid_next;
    logic [55:0] m_tdata_reg, m_tdata_next;
    logic [2:0]  m_tuser_reg, m_tuser_next;

    // Mark memory
    addr_t             mark_mem   [MEM_DEPTH];
    addr_t             rd_data_reg[AREA_COUNT];
    logic              mem_we;
    logic [MEM_AW-1:0] mem_waddr;
    addr_t             mem_wdata;

    logic  s_accept;
    logic  out_free;
    need_t need;
    fit_t  fit_res [AREA_COUNT];
    addr_t rwd_val [AREA_COUNT];

    // Handshake
    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE) || ((state_reg == S_DONE) && out_free);
    assign s_accept = s_tvalid && s_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // Round the request up to whole words at full width
    assign need = ({1'b0, size_reg} + NEED_W'(3)) & {{(NEED_W-2){1'b1}}, 2'b00};

    // Room and fit per area against the cached tops
    for (genvar g = 0; g < AREA_COUNT; g++) begin : g_area
        mrsa_fit u_fit (
            .top      (top_reg[g]),
            .end_addr (cfg_end_reg[g]),
            .need     (need),
            .result   (fit_res[g])
        );
        assign rwd_val[g] = locked_reg ? lock_reg[g] : cfg_start_reg[g];
    end

    // Next-state logic
    always_comb begin
        logic  sel;
        logic  hit;
        idx_t  ni;
        addr_t new_top;

        state_next    = state_reg;
        top_next      = top_reg;
        idx_next      = idx_reg;
        lock_next     = lock_reg;
        locked_next   = locked_reg;
        loaded_next   = loaded_reg;
        func_next     = func_reg;
        area_next     = area_reg;
        size_next     = size_reg;
        addr_next     = addr_reg;
        blk_next      = blk_reg;
        status_next   = status_reg;
        served_next   = served_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        mem_we        = 1'b0;
        mem_waddr     = '0;
        mem_wdata     = '0;
        sel           = 1'b0;
        hit           = 1'b0;
        ni            = '0;
        new_top       = '0;

        // Drop the result once taken
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
            end
            S_EXEC: begin
                state_next = S_DONE;
                unique case (func_reg)
                    FUNC_ALLOC: begin
                        // Preferred area first, then the other one
                        if (fit_res[area_reg].fits) begin
                            sel = area_reg;
                            hit = 1'b1;
                        end else if (fit_res[~area_reg].fits) begin
                            sel = ~area_reg;
                            hit = 1'b1;
                        end
                        if (hit) begin
                            ni            = ring_next(idx_reg[sel]);
                            new_top       = top_reg[sel] + need[ADDR_W-1:0];
                            idx_next[sel] = ni;
                            top_next[sel] = new_top;
                            mem_we        = 1'b1;
                            mem_waddr     = mem_addr(sel, ni);
                            mem_wdata     = new_top;
                            blk_next      = top_reg[sel];
                            served_next   = sel;
                            status_next   = STAT_OK;
                        end else begin
                            status_next = STAT_NO_SPACE;
                        end
                    end
                    FUNC_FREE: begin
                        // Pop the lowest area whose previous mark matches
                        priority if (rd_data_reg[0] == addr_reg) begin
                            idx_next[0] = ring_prev(idx_reg[0]);
                            top_next[0] = addr_reg;
                            served_next = 1'b0;
                        end else if (rd_data_reg[1] == addr_reg) begin
                            idx_next[1] = ring_prev(idx_reg[1]);
                            top_next[1] = addr_reg;
                            served_next = 1'b1;
                        end else begin
                            status_next = STAT_BAD_FREE;
                        end
                    end
                    FUNC_REWIND: begin
                        state_next = S_RW0;
                    end
                    FUNC_LOCK: begin
                        lock_next   = top_reg;
                        locked_next = 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
            S_RW0: begin
                // Reload both stacks; base mark of area zero goes to memory
                for (int a = 0; a < AREA_COUNT; a++) begin
                    top_next[a] = rwd_val[a];
                    idx_next[a] = '0;
                end
                mem_we      = 1'b1;
                mem_waddr   = mem_addr(1'b0, '0);
                mem_wdata   = rwd_val[0];
                loaded_next = 1'b1;
                state_next  = S_RW1;
            end
            S_RW1: begin
                // Base mark of area one, already in its cached top
                mem_we     = 1'b1;
                mem_waddr  = mem_addr(1'b1, '0);
                mem_wdata  = top_reg[1];
                state_next = (func_reg == FUNC_REWIND) ? S_DONE : S_EXEC;
            end
            S_DONE: begin
                // Load the result with the post-operation room of the asked area
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {fit_res[area_reg].room, blk_reg};
                    m_tuser_next  = {served_reg, status_reg};
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        // Take a new transaction
        if (s_accept) begin
            func_next   = s_tuser[1:0];
            area_next   = s_tuser[2];
            size_next   = s_tdata[27:0];
            addr_next   = s_tdata[55:28];
            blk_next    = '0;
            status_next = STAT_OK;
            served_next = 1'b0;
            state_next  = loaded_reg ? S_EXEC : S_RW0;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            idx_reg      <= '{default: '0};
            locked_reg   <= 1'b0;
            loaded_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            idx_reg      <= idx_next;
            locked_reg   <= locked_next;
            loaded_reg   <= loaded_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        top_reg     <= top_next;
        lock_reg    <= lock_next;
        func_reg    <= func_next;
        area_reg    <= area_next;
        size_reg    <= size_next;
        addr_reg    <= addr_next;
        blk_reg     <= blk_next;
        status_reg  <= status_next;
        served_reg  <= served_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_start_reg[0] <= AREA0_START_RST;
            cfg_start_reg[1] <= AREA1_START_RST;
            cfg_end_reg[0]   <= AREA0_END_RST;
            cfg_end_reg[1]   <= AREA1_END_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_AREA0_START: cfg_start_reg[0] <= cfg_wdata;
                REG_AREA1_START: cfg_start_reg[1] <= cfg_wdata;
                REG_AREA0_END:   cfg_end_reg[0]   <= cfg_wdata;
                REG_AREA1_END:   cfg_end_reg[1]   <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // Mark memory: one write port, previous marks of both areas read on accept
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mark_mem[mem_waddr] <= mem_wdata;
        end
        if (s_accept) begin
            rd_data_reg[0] <= mark_mem[mem_addr(1'b0, ring_prev(idx_reg[0]))];
            rd_data_reg[1] <= mark_mem[mem_addr(1'b1, ring_prev(idx_reg[1]))];
        end
    end

    // Memory writes only from the execute and reload steps, never with a read
    a_write_state: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> ((state_reg == S_EXEC) || (state_reg == S_RW0) || (state_reg == S_RW1))
                   && !s_accept)
        else $error("mark memory written outside execute or reload");

    // Ring indexes stay within the ring
    a_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (idx_reg[0] <= IDX_W'(MARK_DEPTH - 1)) && (idx_reg[1] <= IDX_W'(MARK_DEPTH - 1)))
        else $error("ring index out of range");

    // Execution only runs on loaded stacks
    a_exec_loaded: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_EXEC) |-> loaded_reg)
        else $error("operation executed before the stacks were loaded");

    // Second reload step sees both indexes at the base
    a_reload_base: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_RW1) |-> ((idx_reg[0] == '0) && (idx_reg[1] == '0)
                                  && $past(state_reg == S_RW0)))
        else $error("reload did not reset ring indexes");

endmodule : mark_release_stack_allocator

`default_nettype wire
